FILE: rtl/mouse_motion_accumulator_macros.svh
// ---------------------------------------------------------------------------
// Mouse motion accumulator assertion macros
// Short forms for the concurrent checks in the accumulator RTL.
// ---------------------------------------------------------------------------
`ifndef MOUSE_MOTION_ACCUMULATOR_MACROS_SVH
`define MOUSE_MOTION_ACCUMULATOR_MACROS_SVH

// Check on every rising clock edge outside reset.
`define MMA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check on every rising clock edge, reset included.
`define MMA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

FILE: rtl/mma_pkg.sv
// ---------------------------------------------------------------------------
// Mouse motion accumulator package
// Widths, codes and arithmetic helpers for the accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

package mma_pkg;

   localparam int ACC_WIDTH = 16;

   localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

   localparam logic signed [ACC_WIDTH-1:0] BYTE_MAX = ACC_WIDTH'(127);
   localparam logic signed [ACC_WIDTH-1:0] BYTE_MIN = -ACC_WIDTH'(128);

   localparam logic [7:0] REPORT_MARK = 8'h80;

   typedef enum logic {
      CMD_PACKET = 1'b0,
      CMD_READ   = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_TAKEN   = 2'd0,
      STATUS_REPORT  = 2'd1,
      STATUS_NO_DATA = 2'd2
   } status_type;

   // Saturate a one-bit-wider sum back to the accumulator range.
   function automatic logic signed [ACC_WIDTH-1:0] sat_acc(
      input logic signed [ACC_WIDTH:0] value
   );
      logic signed [ACC_WIDTH-1:0] result;
      if (value > ACC_MAX) begin
         result = ACC_MAX;
      end else if (value < ACC_MIN) begin
         result = ACC_MIN;
      end else begin
         result = value[ACC_WIDTH-1:0];
      end
      return result;
   endfunction

   // Clamp an accumulator to one signed report byte.
   function automatic logic signed [7:0] clamp_byte(
      input logic signed [ACC_WIDTH-1:0] value
   );
      logic signed [7:0] result;
      if (value > BYTE_MAX) begin
         result = BYTE_MAX[7:0];
      end else if (value < BYTE_MIN) begin
         result = BYTE_MIN[7:0];
      end else begin
         result = value[7:0];
      end
      return result;
   endfunction

   // Widen a signed byte to the sum width.
   function automatic logic signed [ACC_WIDTH:0] widen_byte(
      input logic signed [7:0] value
   );
      return {{(ACC_WIDTH-7){value[7]}}, value};
   endfunction

endpackage

`default_nettype wire

FILE: rtl/mouse_motion_accumulator.sv
// ---------------------------------------------------------------------------
// Mouse motion accumulator
// Bus-mouse style delta accumulator with clamped, draining reports.
// ---------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one transaction per motion packet (req_cmd low)
//   or per report read (req_cmd high). Every request transaction gives
//   exactly one rsp_ transaction: packet taken, a report, or no data.
//   Both channels use valid/stall; a transaction moves at a rising edge
//   with valid high and stall low.
//   A request accepted is held in the input register, processed by the
//   add/clamp/subtract logic and shown on rsp_ once the result register
//   is free. Throughput: one transaction per cycle while rsp_stall is
//   low; the input register and the result register each hold one, so
//   a new request is taken while a finished result waits.
//   The accumulators and ready flag update at the moment a request moves
//   from the input register into the result register, so back-to-back
//   requests see each other's effects in order.
//   Reset (synchronous, active high) clears both accumulators, the button
//   state, the ready flag and both valid bits.
//   When rsp_stall is high the result holds; a following request waits in
//   the input register, and req_stall rises only once that register is
//   full and cannot drain.
// ---------------------------------------------------------------------------
`default_nettype none

`include "mouse_motion_accumulator_macros.svh"

module mouse_motion_accumulator (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire logic              req_cmd,
   input  wire logic [7:0]        req_header_byte,
   input  wire logic signed [7:0] req_delta_x,
   input  wire logic signed [7:0] req_delta_y,
   input  wire logic              req_middle_button,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic [1:0]        rsp_status,
   output      logic [7:0]        rsp_report_buttons,
   output      logic signed [7:0] rsp_report_dx,
   output      logic signed [7:0] rsp_report_dy,
   output      logic              rsp_data_ready
);

   // Input register.
   logic              in_valid_ff;
   logic              in_cmd_ff;
   logic [1:0]        in_header_ff;
   logic signed [7:0] in_dx_ff;
   logic signed [7:0] in_dy_ff;
   logic              in_middle_ff;

   // Architectural state.
   logic signed [mma_pkg::ACC_WIDTH-1:0] accum_x_ff, accum_x_in;
   logic signed [mma_pkg::ACC_WIDTH-1:0] accum_y_ff, accum_y_in;
   logic [2:0]        button_ff, button_in;
   logic              ready_ff, ready_in;

   // Result register.
   logic              out_valid_ff;
   mma_pkg::status_type out_status_ff, out_status_in;
   logic [7:0]        out_buttons_ff, out_buttons_in;
   logic signed [7:0] out_dx_ff, out_dx_in;
   logic signed [7:0] out_dy_ff, out_dy_in;
   logic              out_ready_ff;

   logic              out_load;
   logic              in_load;
   logic signed [7:0] clamp_x;
   logic signed [7:0] clamp_y;
   logic signed [mma_pkg::ACC_WIDTH-1:0] drain_x;
   logic signed [mma_pkg::ACC_WIDTH-1:0] drain_y;

   // Advance the held request when the result register is empty or draining.
   assign out_load  = in_valid_ff && (!out_valid_ff || !rsp_stall);
   // Stall the requester only when the input register is full and stuck.
   assign req_stall = in_valid_ff && !out_load;
   assign in_load   = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load) begin
         in_valid_ff <= 1'b1;
      end else if (out_load) begin
         in_valid_ff <= 1'b0;
      end
   end

   // Payload: capture on accept, no reset needed.
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_cmd_ff    <= req_cmd;
         in_header_ff <= req_header_byte[1:0];
         in_dx_ff     <= req_delta_x;
         in_dy_ff     <= req_delta_y;
         in_middle_ff <= req_middle_button;
      end
   end

   // Report amounts and what remains after a read.
   assign clamp_x = mma_pkg::clamp_byte(accum_x_ff);
   assign clamp_y = mma_pkg::clamp_byte(accum_y_ff);
   assign drain_x = accum_x_ff - {{(mma_pkg::ACC_WIDTH-8){clamp_x[7]}}, clamp_x};
   assign drain_y = accum_y_ff - {{(mma_pkg::ACC_WIDTH-8){clamp_y[7]}}, clamp_y};

   always_comb begin
      accum_x_in     = accum_x_ff;
      accum_y_in     = accum_y_ff;
      button_in      = button_ff;
      ready_in       = ready_ff;
      out_status_in  = mma_pkg::STATUS_TAKEN;
      out_buttons_in = 8'd0;
      out_dx_in      = 8'sd0;
      out_dy_in      = 8'sd0;
      case (mma_pkg::cmd_type'(in_cmd_ff))
         mma_pkg::CMD_PACKET: begin
            // Buttons arrive active low: first, middle, second.
            button_in  = ~{in_header_ff[1], in_middle_ff, in_header_ff[0]};
            accum_x_in = mma_pkg::sat_acc({accum_x_ff[mma_pkg::ACC_WIDTH-1], accum_x_ff}
                                          + mma_pkg::widen_byte(in_dx_ff));
            accum_y_in = mma_pkg::sat_acc({accum_y_ff[mma_pkg::ACC_WIDTH-1], accum_y_ff}
                                          - mma_pkg::widen_byte(in_dy_ff));
            ready_in   = 1'b1;
         end
         mma_pkg::CMD_READ: begin
            if (!ready_ff) begin
               out_status_in = mma_pkg::STATUS_NO_DATA;
            end else begin
               // Report the clamped part, keep the rest for later reads.
               accum_x_in     = drain_x;
               accum_y_in     = drain_y;
               ready_in       = (drain_x != '0) || (drain_y != '0);
               out_status_in  = mma_pkg::STATUS_REPORT;
               out_buttons_in = mma_pkg::REPORT_MARK | {5'd0, button_ff};
               out_dx_in      = clamp_x;
               out_dy_in      = clamp_y;
            end
         end
         default: begin
            out_status_in = mma_pkg::STATUS_TAKEN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_x_ff <= '0;
         accum_y_ff <= '0;
         button_ff  <= 3'd0;
         ready_ff   <= 1'b0;
      end else if (out_load) begin
         accum_x_ff <= accum_x_in;
         accum_y_ff <= accum_y_in;
         button_ff  <= button_in;
         ready_ff   <= ready_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_status_ff  <= out_status_in;
         out_buttons_ff <= out_buttons_in;
         out_dx_ff      <= out_dx_in;
         out_dy_ff      <= out_dy_in;
         out_ready_ff   <= ready_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_report_buttons = out_buttons_ff;
   assign rsp_report_dx      = out_dx_ff;
   assign rsp_report_dy      = out_dy_ff;
   assign rsp_data_ready     = out_ready_ff;

   // Ready may only be clear once both accumulators have drained.
   `MMA_ASSERT(a_idle_drained,
      !ready_ff |-> (accum_x_ff == '0 && accum_y_ff == '0),
      "ready clear with motion left")
   // A no-data result never claims data is ready.
   `MMA_ASSERT(a_no_data_flag,
      (out_valid_ff && out_status_ff == mma_pkg::STATUS_NO_DATA) |-> !out_ready_ff,
      "no-data result with ready set")
   // A packet always leaves data ready.
   `MMA_ASSERT(a_packet_flag,
      (out_valid_ff && out_status_ff == mma_pkg::STATUS_TAKEN) |-> out_ready_ff,
      "packet result without ready")
   // A request moved to the result register shows up there next cycle.
   `MMA_ASSERT(a_load_shows, out_load |=> out_valid_ff, "loaded result not valid")
   // Nothing is presented right after reset.
   `MMA_ASSERT_ALWAYS(a_reset_empty,
      reset |=> (!out_valid_ff && !in_valid_ff),
      "valid after reset")

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// ---------------------------------------------------------------------------
// Mouse motion accumulator testbench
// Sends motion packets and report reads over the req_ channel and checks
// every rsp_ transaction against a cycle-free model of the accumulators:
// button inversion, saturating accumulation, clamped draining reports and
// the ready flag. Both channels idle and stall at random throughout.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200_000;

   // One request transaction as it travels on the req_ ports.
   typedef struct {
      mma_pkg::cmd_type  cmd;
      logic [7:0]        header;
      logic signed [7:0] dx;
      logic signed [7:0] dy;
      logic              middle;
   } motion_req_type;

   // One response transaction as it should appear on the rsp_ ports.
   typedef struct {
      mma_pkg::status_type status;
      logic [7:0]        buttons;
      logic signed [7:0] dx;
      logic signed [7:0] dy;
      logic              ready;
   } motion_rsp_type;

   logic              clock;
   logic              reset             = 1'b1;
   logic              req_valid         = 1'b0;
   logic              req_stall;
   logic              req_cmd           = mma_pkg::CMD_PACKET;
   logic [7:0]        req_header_byte   = 8'h00;
   logic signed [7:0] req_delta_x       = 8'sd0;
   logic signed [7:0] req_delta_y       = 8'sd0;
   logic              req_middle_button = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall         = 1'b0;
   logic [1:0]        rsp_status;
   logic [7:0]        rsp_report_buttons;
   logic signed [7:0] rsp_report_dx;
   logic signed [7:0] rsp_report_dy;
   logic              rsp_data_ready;

   // Model state: the accumulators live in a wide integer but never leave
   // the signed ACC_WIDTH range.
   longint            pos_x       = 0;
   longint            pos_y       = 0;
   logic [2:0]        btn_state   = 3'b000;
   logic              have_motion = 1'b0;

   // Responses predicted but not yet seen, oldest first.
   motion_rsp_type    awaited_rsp[$];
   int                mismatch_count = 0;
   int                cycle_count    = 0;

   // Sender burst shaping and receiver stall shaping.
   int                burst_left    = 8;
   bit                steady_sender = 1'b0;
   int                hold_left     = 0;
   int                stall_pct     = 0;
   int                phase_left    = 0;

   mouse_motion_accumulator dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_header_byte    (req_header_byte),
      .req_delta_x        (req_delta_x),
      .req_delta_y        (req_delta_y),
      .req_middle_button  (req_middle_button),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_report_buttons (rsp_report_buttons),
      .rsp_report_dx      (rsp_report_dx),
      .rsp_report_dy      (rsp_report_dy),
      .rsp_data_ready     (rsp_data_ready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Model arithmetic
   // ------------------------------------------------------------------------

   // Saturate to the signed accumulator range.
   function automatic longint limit_acc(input longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (mma_pkg::ACC_WIDTH - 1)) - 1;
      lo = -(longint'(1) <<< (mma_pkg::ACC_WIDTH - 1));
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // Clamp to one signed report byte.
   function automatic longint limit_report(input longint v);
      if (v > 127) return 127;
      if (v < -128) return -128;
      return v;
   endfunction

   // Apply one request to the model state and return the response it gives.
   function automatic motion_rsp_type accumulate_motion(input motion_req_type rq);
      motion_rsp_type r;
      longint         rx;
      longint         ry;
      r.status  = mma_pkg::STATUS_TAKEN;
      r.buttons = 8'h00;
      r.dx      = 8'sd0;
      r.dy      = 8'sd0;
      if (rq.cmd == mma_pkg::CMD_PACKET) begin
         // First button at bit 0, middle at bit 1, second at bit 2; store
         // inverted. Upper header bits play no part.
         btn_state   = ~{rq.header[1], rq.middle, rq.header[0]};
         pos_x       = limit_acc(pos_x + rq.dx);
         pos_y       = limit_acc(pos_y - rq.dy);
         have_motion = 1'b1;
      end else if (!have_motion) begin
         r.status = mma_pkg::STATUS_NO_DATA;
      end else begin
         // Report at most one byte of motion and keep the remainder.
         rx    = limit_report(pos_x);
         ry    = limit_report(pos_y);
         pos_x = pos_x - rx;
         pos_y = pos_y - ry;
         if (pos_x == 0 && pos_y == 0) have_motion = 1'b0;
         r.status  = mma_pkg::STATUS_REPORT;
         r.buttons = mma_pkg::REPORT_MARK | {5'b00000, btn_state};
         r.dx      = rx[7:0];
         r.dy      = ry[7:0];
      end
      r.ready = have_motion;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   function automatic motion_req_type make_req(input mma_pkg::cmd_type c,
                                               input logic [7:0] h,
                                               input logic signed [7:0] x,
                                               input logic signed [7:0] y,
                                               input logic m);
      motion_req_type rq;
      rq.cmd    = c;
      rq.header = h;
      rq.dx     = x;
      rq.dy     = y;
      rq.middle = m;
      return rq;
   endfunction

   // Random request; small_pct of packets carry tiny deltas so that the
   // accumulators often return to zero.
   function automatic motion_req_type random_req(input int read_pct, input int small_pct);
      motion_req_type rq;
      rq.cmd    = ($urandom_range(0, 99) < read_pct) ? mma_pkg::CMD_READ
                                                     : mma_pkg::CMD_PACKET;
      rq.header = 8'($urandom_range(0, 255));
      rq.middle = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < small_pct) begin
         rq.dx = 8'($signed($urandom_range(0, 6)) - 3);
         rq.dy = 8'($signed($urandom_range(0, 6)) - 3);
      end else begin
         rq.dx = 8'($urandom_range(0, 255));
         rq.dy = 8'($urandom_range(0, 255));
      end
      return rq;
   endfunction

   // Offer one transaction and hold it until the block takes it. Valid stays
   // high for a following call in the same step unless the burst is over.
   task automatic send_motion(input motion_req_type rq);
      req_valid         <= 1'b1;
      req_cmd           <= rq.cmd;
      req_header_byte   <= rq.header;
      req_delta_x       <= rq.dx;
      req_delta_y       <= rq.dy;
      req_middle_button <= rq.middle;
      do @(posedge clock); while (req_stall);
      awaited_rsp.push_back(accumulate_motion(rq));
      burst_left--;
      if (burst_left <= 0) begin
         // Mostly short bursts, now and then a long unbroken one.
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
         if (!steady_sender) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   // Drop valid and wait until every predicted response has arrived.
   task automatic await_all_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_rsp.size() != 0);
   endtask

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------

   // Stall pattern: phases of random length, each with its own stall rate,
   // overridden by a long hold-off when a test asks for one.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(20, 120);
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 25;
               2: stall_pct = 50;
               default: stall_pct = 85;
            endcase
         end else begin
            phase_left--;
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Compare every accepted response with the oldest prediction.
   always @(posedge clock) begin
      motion_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: status %0d buttons %02h dx %0d dy %0d ready %0b",
                        rsp_status, rsp_report_buttons, rsp_report_dx, rsp_report_dy,
                        rsp_data_ready);
         end else begin
            want = awaited_rsp.pop_front();
            if (want.status !== rsp_status || want.buttons !== rsp_report_buttons ||
                want.dx !== rsp_report_dx || want.dy !== rsp_report_dy ||
                want.ready !== rsp_data_ready) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("response mismatch at cycle %0d", cycle_count);
                  $display("  expected status %0d buttons %02h dx %0d dy %0d ready %0b",
                           want.status, want.buttons, want.dx, want.dy, want.ready);
                  $display("  actual   status %0d buttons %02h dx %0d dy %0d ready %0b",
                           rsp_status, rsp_report_buttons, rsp_report_dx, rsp_report_dy,
                           rsp_data_ready);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Hand-picked transactions: reads with nothing pending, button mapping,
   // ignored header bits, delta extremes and reports that drain a remainder.
   task automatic test_directed_cases();
      // Read straight after reset: no data.
      send_motion(make_req(mma_pkg::CMD_READ,   8'h00,  8'sd0,    8'sd0,   1'b0));
      // Zero motion still sets ready; the read then clears it at once.
      send_motion(make_req(mma_pkg::CMD_PACKET, 8'h00,  8'sd0,    8'sd0,   1'b0));
      send_motion(make_req(mma_pkg::CMD_READ,   8'h00,  8'sd0,    8'sd0,   1'b0));
      send_motion(make_req(mma_pkg::CMD_READ,   8'hFF,  8'sd127,  -8'sd128, 1'b1));
      // All buttons released, then upper header bits only, all pressed.
      send_motion(make_req(mma_pkg::CMD_PACKET, 8'hFF,  8'sd127,  -8'sd128, 1'b1));
      send_motion(make_req(mma_pkg::CMD_PACKET, 8'hFC,  8'sd127,  -8'sd128, 1'b0));
      // Drain 254/256 over three reads, ready clears on the last.
      send_motion(make_req(mma_pkg::CMD_READ,   8'h00,  8'sd0,    8'sd0,   1'b0));
      send_motion(make_req(mma_pkg::CMD_READ,   8'h00,  8'sd0,    8'sd0,   1'b0));
      send_motion(make_req(mma_pkg::CMD_READ,   8'h00,  8'sd0,    8'sd0,   1'b0));
      send_motion(make_req(mma_pkg::CMD_READ,   8'h00,  8'sd0,    8'sd0,   1'b0));
      // Each button released on its own, negative extremes.
      send_motion(make_req(mma_pkg::CMD_PACKET, 8'h01, -8'sd128,  8'sd127, 1'b0));
      send_motion(make_req(mma_pkg::CMD_PACKET, 8'h02, -8'sd128,  8'sd127, 1'b0));
      send_motion(make_req(mma_pkg::CMD_PACKET, 8'h00, -8'sd1,    8'sd1,   1'b1));
      send_motion(make_req(mma_pkg::CMD_READ,   8'h00,  8'sd0,    8'sd0,   1'b0));
      send_motion(make_req(mma_pkg::CMD_READ,   8'h00,  8'sd0,    8'sd0,   1'b0));
      send_motion(make_req(mma_pkg::CMD_READ,   8'h00,  8'sd0,    8'sd0,   1'b0));
      // Opposite motion cancels: one axis zero, the other not.
      send_motion(make_req(mma_pkg::CMD_PACKET, 8'h03,  8'sd1,    8'sd0,   1'b1));
      send_motion(make_req(mma_pkg::CMD_PACKET, 8'h00, -8'sd1,    8'sd5,   1'b0));
      send_motion(make_req(mma_pkg::CMD_READ,   8'h00,  8'sd0,    8'sd0,   1'b0));
      send_motion(make_req(mma_pkg::CMD_READ,   8'h00,  8'sd0,    8'sd0,   1'b0));
      await_all_responses();
   endtask

   // Even mix of packets and reads, most over the full field ranges.
   task automatic test_random_mix();
      repeat (420) send_motion(random_req(50, 30));
      await_all_responses();
   endtask

   // Push X to its positive limit and Y to its negative limit with a run of
   // large packets, then drain both through long sequences of reads.
   task automatic test_saturation_and_drain();
      motion_req_type rq;
      repeat (320) begin
         rq = random_req(4, 0);
         rq.dx = ($urandom_range(0, 99) < 85) ? 8'sd127 : 8'($urandom_range(100, 127));
         rq.dy = ($urandom_range(0, 99) < 85) ? 8'sd127 : 8'($urandom_range(100, 127));
         send_motion(rq);
      end
      repeat (300) send_motion(random_req(92, 100));
      await_all_responses();
   endtask

   // Hold the receiver off for a long stretch while the sender keeps
   // offering back-to-back, so the block fills and stalls its input.
   task automatic test_backpressure();
      steady_sender = 1'b1;
      hold_left     = 200;
      repeat (24) send_motion(random_req(50, 30));
      steady_sender = 1'b0;
      await_all_responses();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_mix();
      test_backpressure();
      test_saturation_and_drain();

      // Let the pipeline settle, then count anything still outstanding.
      repeat (10) @(posedge clock);
      mismatch_count += awaited_rsp.size();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire
